### rtl/min_tracking_stack_top_macros.svh
// ----------------------------------------------------------------------------
// Min-tracking stack assertion macros
// Concurrent assertion wrappers; the bodies are empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_TOP_MACROS_SVH
`define MIN_TRACKING_STACK_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Assertion clocked on clk, disabled while the active-low reset is low
`define MST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion clocked on clk that also holds during reset
`define MST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MST_ASSERT(lbl, clk, rst_n, prop, msg)
`define MST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/mst_pkg.sv
// ----------------------------------------------------------------------------
// Min-tracking stack package
// Payload types and operation and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mst_pkg;

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic signed [31:0] min_value;
    logic               is_empty;
    logic [1:0]         status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic    push;
    logic    pop;
    logic    load_out;
    logic    load_rd;
    status_e status;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic multi;
  } dp_status_t;

endpackage

### rtl/mst_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mst_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/mst_ctrl.sv
// ----------------------------------------------------------------------------
// Min-tracking stack controller
// Input acceptance, read-wait sequencing and output register valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "min_tracking_stack_top_macros.svh"

module mst_ctrl
  import mst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RD   = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept, is_push, is_pop, need_rd;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_push    = (action_i == ACT_PUSH);
  assign is_pop     = (action_i == ACT_POP);

  always_comb begin
    cmd_o.push     = accept && is_push && !sts_i.full;
    cmd_o.pop      = accept && is_pop && !sts_i.empty;
    // a pop that leaves entries must fetch the new top from the RAM
    need_rd        = cmd_o.pop && sts_i.multi;
    cmd_o.load_out = accept && !need_rd;
    cmd_o.load_rd  = (state_q == ST_RD);
    if (is_push && sts_i.full) begin
      cmd_o.status = STS_FULL;
    end else if (is_pop && sts_i.empty) begin
      cmd_o.status = STS_EMPTY;
    end else begin
      cmd_o.status = STS_OK;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (need_rd) state_d = ST_RD;
      ST_RD:   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out || cmd_o.load_rd) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `MST_ASSERT(a_rd_out_free, clk_i, rst_ni, (state_q == ST_RD) |-> !out_valid_q, "output busy during read")
  `MST_ASSERT(a_rd_follows_pop, clk_i, rst_ni, need_rd |=> (state_q == ST_RD), "read wait missed")
  `MST_ASSERT(a_one_load, clk_i, rst_ni, !(cmd_o.load_out && cmd_o.load_rd), "two result loads")

endmodule

### rtl/mst_datapath.sv
// ----------------------------------------------------------------------------
// Min-tracking stack datapath
// Entry count, running minimum, cached top difference, store and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "min_tracking_stack_top_macros.svh"

module mst_datapath
  import mst_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] value_i,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         sts_o,
  output out_item_t          out_data_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]      cnt_q, cnt_d;
  logic signed [31:0] min_q, min_d;
  logic [32:0]        top_q, top_d;
  logic [32:0]        push_diff;
  logic [CW-1:0]      rd_cnt;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [32:0]        wdata, rdata;
  logic [CW-1:0]      sel_cnt;
  logic signed [31:0] sel_min;
  logic [32:0]        sel_top;
  logic               top_pos;
  out_item_t          out_q;

  assign sts_o.full  = (cnt_q == CW'(DEPTH));
  assign sts_o.empty = (cnt_q == '0);
  assign sts_o.multi = (cnt_q >= CW'(2));

  assign push_diff = {value_i[31], value_i} - {min_q[31], min_q};
  assign rd_cnt    = cnt_q - CW'(2);
  assign raddr     = rd_cnt[AW-1:0];

  always_comb begin
    cnt_d = cnt_q;
    min_d = min_q;
    top_d = top_q;
    we    = 1'b0;
    waddr = cnt_q[AW-1:0];
    wdata = push_diff;
    if (cmd_i.push) begin
      we = 1'b1;
      if (sts_o.empty) begin
        cnt_d = CW'(1);
        min_d = value_i;
        top_d = '0;
        wdata = '0;
      end else begin
        cnt_d = cnt_q + CW'(1);
        top_d = push_diff;
        if (push_diff[32]) min_d = value_i;
      end
    end else if (cmd_i.pop) begin
      cnt_d = cnt_q - CW'(1);
      // a negative difference marks where the minimum was lowered
      if (top_q[32]) min_d = min_q - top_q[31:0];
    end else if (cmd_i.load_rd) begin
      top_d = rdata;
    end
  end

  mst_ram #(
    .WIDTH(33),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      min_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      min_q <= min_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  // result view of the stack after the operation
  always_comb begin
    if (cmd_i.load_rd) begin
      sel_cnt = cnt_q;
      sel_min = min_q;
      sel_top = rdata;
    end else begin
      sel_cnt = cnt_d;
      sel_min = min_d;
      sel_top = top_d;
    end
    top_pos = !sel_top[32] && (sel_top[31:0] != '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out || cmd_i.load_rd) begin
      out_q.status <= cmd_i.load_rd ? STS_OK : cmd_i.status;
      if (sel_cnt == '0) begin
        out_q.top_value <= '0;
        out_q.min_value <= '0;
        out_q.is_empty  <= 1'b1;
      end else begin
        out_q.top_value <= top_pos ? (sel_min + sel_top[31:0]) : sel_min;
        out_q.min_value <= sel_min;
        out_q.is_empty  <= 1'b0;
      end
    end
  end

  assign out_data_o = out_q;

  `MST_ASSERT_ALWAYS(a_cnt_range, clk_i, !rst_ni || (cnt_q <= CW'(DEPTH)), "count beyond depth")
  `MST_ASSERT(a_push_room, clk_i, rst_ni, cmd_i.push |-> !sts_o.full, "push into full stack")
  `MST_ASSERT(a_pop_count, clk_i, rst_ni, cmd_i.pop |=> (cnt_q == $past(cnt_q) - CW'(1)), "pop count")

endmodule

### rtl/min_tracking_stack_top.sv
// ----------------------------------------------------------------------------
// Min-tracking stack
// LIFO of signed 32-bit values that reports the running minimum.
// ----------------------------------------------------------------------------
// Every operation gives one result. Push, peek, dropped operations and a pop
// that empties the stack load the result register directly; a pop that leaves
// entries waits in the read state, since the new top difference comes from the
// store's registered read port, and the input stalls while it waits. One
// operation is in flight at a time; the next operation is taken no earlier than
// the edge at which the previous result is taken, so the input stalls while a
// result is held by output stall. The store needs no clearing pass: only entries
// below the fill count are ever read.
`timescale 1ns / 1ps

module min_tracking_stack_top
  import mst_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  mst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (in_data_i.action),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mst_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .value_i   (in_data_i.value),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_data_o(out_data_o)
  );

endmodule

### sim/min_stack_checker.sv
// ----------------------------------------------------------------------------
// Min-tracking stack checker
// Watches both channels and keeps its own copy of the stack and its minimum.
// Works out the result of every accepted operation and compares each
// returned result, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_stack_checker
  import mst_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        mismatch_cnt_o,
  output int        outstanding_o
);

  logic signed [32:0] diff_mem [DEPTH];
  int                 fill;
  logic signed [31:0] run_min;
  out_item_t          owed_results [$];
  int                 errors;

  initial begin
    errors         = 0;
    mismatch_cnt_o = 0;
    outstanding_o  = 0;
  end

  // Applies one operation to the local stack and returns what the block owes
  task automatic apply_stack_op(input in_item_t op, output out_item_t res);
    longint d;
    res        = '0;
    res.status = STS_OK;
    case (op.action)
      ACT_PUSH: begin
        if (fill >= DEPTH) begin
          res.status = STS_FULL;
        end else if (fill == 0) begin
          diff_mem[0] = '0;
          run_min     = op.value;
          fill        = 1;
        end else begin
          d              = longint'($signed(op.value)) - longint'(run_min);
          diff_mem[fill] = d[32:0];
          fill++;
          if ($signed(op.value) < run_min) run_min = op.value;
        end
      end
      ACT_POP: begin
        if (fill == 0) begin
          res.status = STS_EMPTY;
        end else begin
          fill--;
          d = longint'(diff_mem[fill]);
          // a negative difference marks where the minimum was lowered
          if (d < 0) run_min = 32'(longint'(run_min) - d);
        end
      end
      default: ;  // peek and the spare code leave the stack alone
    endcase
    if (fill == 0) begin
      res.is_empty = 1'b1;
    end else begin
      d             = longint'(diff_mem[fill - 1]);
      res.top_value = (d > 0) ? 32'(longint'(run_min) + d) : run_min;
      res.min_value = run_min;
    end
  endtask

  task automatic flag_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t res;
    out_item_t want;
    if (!rst_ni) begin
      fill    = 0;
      run_min = '0;
      owed_results.delete();
      outstanding_o <= 0;
    end else begin
      // operation first, so a same-edge result would still find its entry
      if (in_valid_i && !in_stall_i) begin
        apply_stack_op(in_data_i, res);
        owed_results.push_back(res);
      end
      if (out_valid_i && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none got %h", $time, out_data_i);
        end else begin
          want = owed_results.pop_front();
          flag_field("top_value", want.top_value, out_data_i.top_value);
          flag_field("min_value", want.min_value, out_data_i.min_value);
          flag_field("is_empty", 32'(want.is_empty), 32'(out_data_i.is_empty));
          flag_field("status", 32'(want.status), 32'(out_data_i.status));
        end
      end
      outstanding_o <= owed_results.size();
    end
    mismatch_cnt_o <= errors;
  end

endmodule

### sim/min_tracking_stack_top_test.sv
// ----------------------------------------------------------------------------
// Min-tracking stack testbench
// Drives directed and random push, pop and peek traffic with random gaps and
// output stalls; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_tracking_stack_top_test;
  import mst_pkg::*;

  localparam int         DEPTH     = 64;
  localparam int         N_RANDOM  = 1850;
  localparam int         LIMIT     = 600000;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_NOISE} mix_e;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        mismatches;
  int        outstanding;
  int        cycles    = 0;
  bit        quiet     = 1'b0;

  min_tracking_stack_top #(.DEPTH(DEPTH)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  min_stack_checker #(.DEPTH(DEPTH)) checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .mismatch_cnt_o(mismatches),
    .outstanding_o (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("min_tracking_stack_top verification failed");
      $finish;
    end
  end

  // mostly no pause, sometimes a short one, rarely a long one
  function automatic int draw_pause();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic logic [31:0] draw_operand();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3:    return 32'($urandom_range(0, 16)) - 32'd8;  // ties with the minimum
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [1:0] draw_action(input mix_e mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  return (r < 80) ? ACT_PUSH : (r < 90) ? ACT_POP : ACT_PEEK;
      MIX_DRAIN: return (r < 80) ? ACT_POP : (r < 90) ? ACT_PUSH : ACT_PEEK;
      MIX_EVEN:  return (r < 45) ? ACT_PUSH : (r < 90) ? ACT_POP : ACT_PEEK;
      default:   return 2'($urandom_range(0, 3));
    endcase
  endfunction

  always begin : stall_gen
    int n;
    @(posedge clk);
    n = draw_pause();
    if (n > 0) begin
      out_stall <= 1'b1;
      repeat (n) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  task automatic send(input logic [1:0] act, input logic [31:0] val);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{action: act, value: val};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = draw_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off the sender until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int   random_items;
    int   phase;
    int   len;
    mix_e mix;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stack: pop refused, peek and the spare code
    send(ACT_POP, 32'h1234_5678);
    send(ACT_PEEK, 32'hffff_ffff);
    send(ACT_SPARE, 32'h0);
    // widest differences both ways
    send(ACT_PUSH, 32'h7fff_ffff);
    send(ACT_PUSH, 32'h8000_0000);
    send(ACT_PUSH, 32'h7fff_ffff);
    send(ACT_PEEK, 32'h5555_5555);
    send(ACT_SPARE, 32'haaaa_aaaa);
    send(ACT_POP, 32'h0);
    send(ACT_POP, 32'h0);
    send(ACT_POP, 32'h0);
    send(ACT_POP, 32'hffff_ffff);
    // ties with the minimum and a new lowest value
    send(ACT_PUSH, 32'h0);
    send(ACT_PUSH, 32'hffff_ffff);
    send(ACT_PUSH, 32'hffff_ffff);
    send(ACT_PUSH, 32'd5);
    send(ACT_PUSH, 32'h8000_0000);
    repeat (5) send(ACT_POP, 32'h0);
    drain_results();

    // fill past the top so pushes get refused, then random phases
    random_items = 0;
    repeat (DEPTH + 4) begin
      send(ACT_PUSH, draw_operand());
      random_items++;
    end
    phase = 0;
    while (random_items < N_RANDOM) begin
      mix   = mix_e'($urandom_range(0, 3));
      quiet = ($urandom_range(0, 3) == 0);
      len   = $urandom_range(20, 130);
      if (phase % 6 == 5) drain_results();
      repeat (len) begin
        send(draw_action(mix), draw_operand());
        random_items++;
      end
      phase++;
    end
    quiet = 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("min_tracking_stack_top verification clean");
    end else begin
      $display("min_tracking_stack_top verification failed");
    end
    $finish;
  end

endmodule
